// File: src/sorted_priority_queue_core_assert.svh
// assertion macros for the sorted priority queue core
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge outside reset
`define SPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked from a trigger condition
`define SPQ_ASSERT_IMP(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
    else $error(msg);

// condition that must hold in the cycle after a trigger
`define SPQ_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error(msg);

`else

`define SPQ_ASSERT(label, prop, msg)
`define SPQ_ASSERT_IMP(label, trig, prop, msg)
`define SPQ_ASSERT_NEXT(label, trig, prop, msg)

`endif

`endif

// File: src/spq_pkg.sv
package spq_pkg;

  // queue depth and derived widths
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  // operation codes, the last one unused and served as a query
  typedef enum logic [1:0] {
    OP_QUERY  = 2'd0,
    OP_ENQ    = 2'd1,
    OP_DEQ    = 2'd2,
    OP_UNUSED = 2'd3
  } spq_op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } spq_status_t;

  typedef logic signed [DATA_W-1:0] spq_word_t;

  // input beat
  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] item_value;
    logic signed [31:0] item_rank;
  } spq_in_t;

  // result beat
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] head_value;
    logic               is_empty;
    logic [4:0]         fill_count;
  } spq_out_t;

  // broadcast from the control to every cell
  typedef struct packed {
    logic      enq;
    logic      deq;
    logic      head_lt;
    spq_word_t new_value;
    spq_word_t new_rank;
  } spq_bcast_t;

endpackage

// File: src/spq_cell.sv
module spq_cell (
  input  logic               clk,
  input  logic               is_head,
  input  logic               occ,
  input  spq_pkg::spq_bcast_t bcast,
  input  spq_pkg::spq_word_t left_value,
  input  spq_pkg::spq_word_t left_rank,
  input  logic               left_ins,
  input  spq_pkg::spq_word_t right_value,
  input  spq_pkg::spq_word_t right_rank,
  output spq_pkg::spq_word_t value,
  output spq_pkg::spq_word_t rank,
  output logic               ins
);
  import spq_pkg::*;

  spq_word_t value_r;
  spq_word_t value_nxt;
  spq_word_t rank_r;
  spq_word_t rank_nxt;

  // this cell lies at or after the insertion point
  assign ins = bcast.head_lt || !occ || (!is_head && (rank_r <= bcast.new_rank));

  // hold, take the new entry, shift right on insert, shift left on removal
  always_comb begin
    value_nxt = value_r;
    rank_nxt  = rank_r;
    if (bcast.enq && ins) begin
      if (left_ins) begin
        value_nxt = left_value;
        rank_nxt  = left_rank;
      end else begin
        value_nxt = bcast.new_value;
        rank_nxt  = bcast.new_rank;
      end
    end else if (bcast.deq) begin
      value_nxt = right_value;
      rank_nxt  = right_rank;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    rank_r  <= rank_nxt;
  end

  assign value = value_r;
  assign rank  = rank_r;

endmodule

// File: src/sorted_priority_queue_core.sv
// channel   ports                      handshake
// input     start, busy, in_item       beat taken when start high and busy low
// result    out_valid, out_item        one-cycle strobe, receiver cannot stall
//
// every beat is handled at once: all cells compare their rank against the new one
// in parallel and shift by one place in the same edge, so busy stays low.
// the result of a beat shows on the cycle after it is taken.
// rst_n (synchronous) clears the fill count and the result strobe; cell
// contents are left as they are and only cells below the fill count are read.
`include "sorted_priority_queue_core_assert.svh"

module sorted_priority_queue_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  spq_pkg::spq_in_t in_item,
  output logic             out_valid,
  output spq_pkg::spq_out_t out_item
);
  import spq_pkg::*;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  spq_status_t      status_r;
  spq_status_t      status_nxt;

  spq_bcast_t       bcast;
  logic             full;
  logic             accept;

  spq_word_t        cell_value [CAPACITY];
  spq_word_t        cell_rank  [CAPACITY];
  logic             cell_ins   [CAPACITY];
  logic             cell_occ   [CAPACITY];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(CAPACITY));

  // decode the beat into cell commands and the status
  always_comb begin
    bcast.enq       = 1'b0;
    bcast.deq       = 1'b0;
    bcast.new_value = in_item.item_value;
    bcast.new_rank  = in_item.item_rank;
    bcast.head_lt   = (count_r == '0) || (cell_rank[0] < in_item.item_rank);
    status_nxt      = ST_DONE;
    count_nxt       = count_r;
    if (accept) begin
      unique case (in_item.operation)
        OP_ENQ: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            bcast.enq = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        OP_DEQ: begin
          if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            bcast.deq = 1'b1;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        default: begin
          status_nxt = ST_DONE;
        end
      endcase
    end
  end

  assign out_valid_nxt = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      status_r    <= ST_DONE;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
    end
  end

  // row of cells, head at index zero
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_word_t left_value;
    spq_word_t left_rank;
    logic      left_ins;
    spq_word_t right_value;
    spq_word_t right_rank;

    assign cell_occ[i] = (count_r > CNT_W'(i));

    if (i == 0) begin : g_first
      assign left_value = '0;
      assign left_rank  = '0;
      assign left_ins   = 1'b0;
    end else begin : g_inner
      assign left_value = cell_value[i-1];
      assign left_rank  = cell_rank[i-1];
      assign left_ins   = cell_ins[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_value = '0;
      assign right_rank  = '0;
    end else begin : g_mid
      assign right_value = cell_value[i+1];
      assign right_rank  = cell_rank[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .is_head     (i == 0),
      .occ         (cell_occ[i]),
      .bcast       (bcast),
      .left_value  (left_value),
      .left_rank   (left_rank),
      .left_ins    (left_ins),
      .right_value (right_value),
      .right_rank  (right_rank),
      .value       (cell_value[i]),
      .rank        (cell_rank[i]),
      .ins         (cell_ins[i])
    );
  end

  // result beat
  assign out_valid           = out_valid_r;
  assign out_item.status     = status_r;
  assign out_item.head_value = (count_r != '0) ? cell_value[0] : '0;
  assign out_item.is_empty   = (count_r == '0);
  assign out_item.fill_count = 5'(count_r);

  // checks
  `SPQ_ASSERT(a_count_bound, count_r <= CNT_W'(CAPACITY), "fill count above capacity")
  `SPQ_ASSERT_NEXT(a_result_follows, accept, out_valid, "accepted beat gave no result")
  `SPQ_ASSERT_NEXT(a_full_drop, accept && (in_item.operation == OP_ENQ) && full,
    (out_item.status == ST_FULL) && $stable(count_r), "enqueue on full changed the queue")
  `SPQ_ASSERT_IMP(a_head_order, cell_occ[1], cell_rank[0] >= cell_rank[1],
    "head rank below second entry")

endmodule

// File: test/sorted_priority_queue_core_tb.sv
`timescale 1ns / 100ps

module sorted_priority_queue_core_tb;
  import spq_pkg::*;

  // one queued beat with the idle cycles the driver waits before it
  typedef struct {
    spq_in_t     beat;
    int unsigned gap;
  } pending_beat_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  spq_in_t  in_item = '0;
  logic     out_valid;
  spq_out_t out_item;

  pending_beat_t pending_beats[$];
  spq_out_t      awaited_results[$];
  int            err_count = 0;
  logic          beat_taken = 1'b0;
  logic          drv_active = 1'b0;
  int unsigned   idle_cycles = 0;
  spq_in_t       cur_beat = '0;

  // shadow copy of the sorted queue
  spq_word_t shadow_value[CAPACITY];
  spq_word_t shadow_rank[CAPACITY];
  int        shadow_fill = 0;

  sorted_priority_queue_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    err_count++;
  endtask

  // apply one beat to the shadow queue and return the result it produces
  function automatic spq_out_t apply_beat(spq_in_t b);
    spq_word_t   new_rank = b.item_rank;
    spq_status_t st = ST_DONE;
    spq_out_t    r;
    int          pos;
    case (b.operation)
      OP_ENQ: begin
        if (shadow_fill >= CAPACITY) begin
          st = ST_FULL;
        end else begin
          // strictly higher than the head goes first; ties with the head go behind it
          if (shadow_fill == 0 || shadow_rank[0] < new_rank) begin
            pos = 0;
          end else begin
            pos = 1;
            while (pos < shadow_fill && shadow_rank[pos] > new_rank) pos++;
          end
          for (int i = shadow_fill; i > pos; i--) begin
            shadow_value[i] = shadow_value[i-1];
            shadow_rank[i]  = shadow_rank[i-1];
          end
          shadow_value[pos] = b.item_value;
          shadow_rank[pos]  = new_rank;
          shadow_fill++;
        end
      end
      OP_DEQ: begin
        if (shadow_fill == 0) begin
          st = ST_EMPTY;
        end else begin
          for (int i = 0; i + 1 < shadow_fill; i++) begin
            shadow_value[i] = shadow_value[i+1];
            shadow_rank[i]  = shadow_rank[i+1];
          end
          shadow_fill--;
        end
      end
      default: st = ST_DONE;  // query and the unused code leave the queue alone
    endcase
    r.status     = st;
    r.head_value = (shadow_fill > 0) ? shadow_value[0] : '0;
    r.is_empty   = (shadow_fill == 0);
    r.fill_count = shadow_fill[4:0];
    return r;
  endfunction

  task automatic add_beat(logic [1:0] op, logic [31:0] val, logic [31:0] rank,
                          int unsigned gap);
    pending_beat_t p;
    p.beat.operation  = op;
    p.beat.item_value = val;
    p.beat.item_rank  = rank;
    p.gap             = gap;
    pending_beats.push_back(p);
  endtask

  // driver: feeds beats at the falling edge, random filler while idle
  always @(negedge clk) begin : beat_driver
    pending_beat_t p;
    logic [65:0]   filler;
    if (!rst_n) begin
      start <= 1'b0;
      in_item <= '0;
      drv_active = 1'b0;
      idle_cycles = 0;
    end else begin
      if (drv_active && beat_taken) drv_active = 1'b0;
      if (!drv_active && pending_beats.size() > 0) begin
        if (idle_cycles < pending_beats[0].gap) begin
          idle_cycles++;
        end else begin
          p = pending_beats.pop_front();
          cur_beat = p.beat;
          drv_active = 1'b1;
          idle_cycles = 0;
        end
      end
      filler = 66'({$urandom, $urandom, $urandom});
      start <= drv_active;
      in_item <= drv_active ? cur_beat : spq_in_t'(filler);
    end
  end

  // monitor: check results and predict each accepted beat at the rising edge
  always @(posedge clk) begin : result_monitor
    spq_out_t want;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result", out_item.head_value, '0);
        end else begin
          want = awaited_results.pop_front();
          if (out_item.status !== want.status)
            report_mismatch("status", 32'(out_item.status), 32'(want.status));
          if (out_item.head_value !== want.head_value)
            report_mismatch("head_value", out_item.head_value, want.head_value);
          if (out_item.is_empty !== want.is_empty)
            report_mismatch("is_empty", 32'(out_item.is_empty), 32'(want.is_empty));
          if (out_item.fill_count !== want.fill_count)
            report_mismatch("fill_count", 32'(out_item.fill_count),
                            32'(want.fill_count));
        end
      end
      if (start && busy === 1'b0) awaited_results.push_back(apply_beat(in_item));
      beat_taken <= start && busy === 1'b0;
    end else begin
      beat_taken <= 1'b0;
    end
  end

  initial begin : stimulus
    int          n;
    int          mode;
    int          len;
    int          r;
    int          rank_mode;
    bit          calm;
    int unsigned gap;
    logic [1:0]  op;
    logic [31:0] rank;

    // directed: empty cases, unused code, extremes and both tie rules
    add_beat(OP_QUERY,  32'hdead_beef, 32'h1234_5678, 0);
    add_beat(OP_DEQ,    32'hffff_ffff, 32'hffff_ffff, 0);
    add_beat(OP_UNUSED, 32'h5555_aaaa, 32'haaaa_5555, 1);
    add_beat(OP_ENQ,    32'h7fff_ffff, 32'h8000_0000, 0);
    add_beat(OP_ENQ,    32'h8000_0000, 32'h7fff_ffff, 2);
    add_beat(OP_ENQ,    32'h0000_0001, 32'h7fff_ffff, 0);
    add_beat(OP_ENQ,    32'h0000_0002, 32'h8000_0000, 0);
    add_beat(OP_ENQ,    32'h0000_0000, 32'h0000_0000, 3);
    add_beat(OP_ENQ,    32'hffff_ffff, 32'hffff_ffff, 0);
    add_beat(OP_DEQ,    32'h0f0f_0f0f, 32'hf0f0_f0f0, 0);
    add_beat(OP_QUERY,  32'hffff_ffff, 32'h0000_0000, 5);
    // fill up to capacity, then push against the full queue
    for (int i = 0; i < CAPACITY - 5; i++)
      add_beat(OP_ENQ, 32'(i + 16), 32'(i - 5), $urandom_range(0, 2));
    add_beat(OP_ENQ, 32'h1111_1111, 32'h7fff_ffff, 0);
    add_beat(OP_ENQ, 32'h2222_2222, 32'h8000_0000, 9);
    add_beat(OP_QUERY, '0, '0, 0);

    // random phases: filling, draining, balanced, noise and dense ties
    n = 0;
    while (n < 1800) begin
      mode = $urandom_range(0, 4);
      len  = $urandom_range(10, 80);
      calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len; k++) begin
        gap = calm ? 0 : $urandom_range(0, 9);
        r = $urandom_range(0, 99);
        case (mode)
          0: op = (r < 75) ? OP_ENQ : (r < 90) ? OP_DEQ : OP_QUERY;
          1: op = (r < 70) ? OP_DEQ : (r < 90) ? OP_ENQ : OP_QUERY;
          3: op = 2'($urandom_range(0, 3));
          default: op = (r < 45) ? OP_ENQ : (r < 90) ? OP_DEQ : OP_QUERY;
        endcase
        rank_mode = (mode == 4) ? 0 : $urandom_range(0, 3);
        case (rank_mode)
          0: rank = 32'($urandom_range(0, 3)) - 32'd1;
          1: begin
            case ($urandom_range(0, 3))
              0: rank = 32'h7fff_ffff;
              1: rank = 32'h8000_0000;
              2: rank = '0;
              default: rank = '1;
            endcase
          end
          default: rank = $urandom;
        endcase
        add_beat(op, $urandom, rank, gap);
        n++;
      end
    end

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // drain everything, then wait for stray results before the final check
    while (pending_beats.size() > 0 || drv_active || awaited_results.size() > 0)
      @(posedge clk);
    repeat (5) @(posedge clk);
    if (awaited_results.size() != 0)
      report_mismatch("missing results", awaited_results.size(), 0);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue_core.sv
test/sorted_priority_queue_core_tb.sv
